[rtl/core/fpdec_pkg.sv]
package fpdec_pkg;

    // Default sizes of the conversion buffer.
    localparam int INT_DIGITS_DEF    = 10;
    localparam int BUFFER_DIGITS_DEF = 24;

    // A 32-bit integer part, plus a rounding carry, never needs more than ten digits.
    localparam int IP_DIGITS = 10;
    localparam int IP_BITS   = 33;
    localparam int BCD_W     = 4;

    // Field widths of the transactions.
    localparam int INT_W  = 32;
    localparam int FRAC_W = 32;
    localparam int CHAR_W = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int PLACES_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_PLACES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MILLISECOND_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_INPUT     = 2'd2;

    localparam logic [PLACES_W-1:0] PLACES_RESET = 4'd6;

    // Millisecond mode moves the point this many places to the right.
    localparam int MS_SHIFT = 3;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

    localparam logic [BCD_W-1:0] DIGIT_NINE = 4'd9;
    localparam logic [BCD_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [BCD_W-1:0] DIGIT_ADJ  = 4'd3;

    // Commands to the binary-to-BCD unit.
    typedef struct packed {
        logic load;
        logic shift;
    } bcd_ctrl_t;

    // Status from the binary-to-BCD unit.
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] head;
    } bcd_stat_t;

endpackage

[rtl/core/fpdec_bcd.sv]
module fpdec_bcd #(
    parameter int NUM_DIGITS = fpdec_pkg::IP_DIGITS,
    parameter int BIN_W      = fpdec_pkg::IP_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fpdec_pkg::bcd_ctrl_t ctrl,
    input  logic [BIN_W-1:0]     bin_in,
    output fpdec_pkg::bcd_stat_t stat
);
    import fpdec_pkg::*;

    localparam int CNT_W  = $clog2(BIN_W + 1);
    localparam int FLAT_W = NUM_DIGITS * BCD_W;

    logic [BIN_W-1:0] val_reg, val_next;
    logic [BCD_W-1:0] dig_reg [NUM_DIGITS];
    logic [BCD_W-1:0] dig_next[NUM_DIGITS];
    logic [BCD_W-1:0] adj     [NUM_DIGITS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [FLAT_W-1:0] flat, shifted;

    // Add three to every digit of five or more, then shift one binary bit in.
    always_comb begin
        for (int j = 0; j < NUM_DIGITS; j++) begin
            adj[j] = (dig_reg[j] >= DIGIT_FIVE) ? dig_reg[j] + DIGIT_ADJ : dig_reg[j];
            flat[(NUM_DIGITS-1-j)*BCD_W +: BCD_W] = adj[j];
        end
        shifted = {flat[FLAT_W-2:0], val_reg[BIN_W-1]};
    end

    // Load, convert one bit a cycle, then hand digits out most significant first.
    always_comb begin
        val_next = val_reg;
        cnt_next = cnt_reg;
        for (int j = 0; j < NUM_DIGITS; j++) begin
            dig_next[j] = dig_reg[j];
        end
        if (ctrl.load) begin
            val_next = bin_in;
            cnt_next = CNT_W'(BIN_W);
            for (int j = 0; j < NUM_DIGITS; j++) begin
                dig_next[j] = '0;
            end
        end else if (cnt_reg != '0) begin
            val_next = {val_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            for (int j = 0; j < NUM_DIGITS; j++) begin
                dig_next[j] = shifted[(NUM_DIGITS-1-j)*BCD_W +: BCD_W];
            end
        end else if (ctrl.shift) begin
            for (int j = 0; j < NUM_DIGITS - 1; j++) begin
                dig_next[j] = dig_reg[j+1];
            end
            dig_next[NUM_DIGITS-1] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        val_reg <= val_next;
        for (int j = 0; j < NUM_DIGITS; j++) begin
            dig_reg[j] <= dig_next[j];
        end
    end

    assign stat.done = (cnt_reg == '0);
    assign stat.head = dig_reg[0];

endmodule

[rtl/core/fixed_point_to_decimal_text.sv]
// The first character leaves after the fraction loop, the load, the conversion and the leading
// zeros, with the moment also set by the sign; then one per cycle while the output is not stalled.
// A new value is taken only after the last one is emitted; each value passes through the fraction
// loop, the 33-step binary-to-BCD conversion and emission.
// Reset (aresetn low, synchronous) restores the registers to six places, seconds and unsigned
// input, and drops any value in progress.
module fixed_point_to_decimal_text #(
    parameter int INT_DIGITS    = fpdec_pkg::INT_DIGITS_DEF,
    parameter int BUFFER_DIGITS = fpdec_pkg::BUFFER_DIGITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [fpdec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpdec_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [fpdec_pkg::INT_W-1:0]      s_int_part,
    input  logic [fpdec_pkg::FRAC_W-1:0]     s_frac_part,
    input  logic                             s_negative_flag,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fpdec_pkg::CHAR_W-1:0]     m_char_code,
    output logic                             m_last_char
);
    import fpdec_pkg::*;

    localparam int FRAC_CAP = (BUFFER_DIGITS > INT_DIGITS) ? BUFFER_DIGITS - INT_DIGITS : 0;
    localparam int SHORT    = (INT_DIGITS > BUFFER_DIGITS) ? INT_DIGITS - BUFFER_DIGITS : 0;
    localparam int FRAC_N   = (FRAC_CAP > 0) ? FRAC_CAP : 1;
    localparam int FIDX_W   = (FRAC_N > 1) ? $clog2(FRAC_N) : 1;
    localparam int NDIG     = IP_DIGITS + FRAC_CAP;
    localparam int REL_W    = $clog2(NDIG + MS_SHIFT + 1);
    localparam int VAL_W    = INT_W + FRAC_W;
    localparam int PROD_W   = FRAC_W + BCD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAC,
        ST_LOAD,
        ST_CONV,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [PLACES_W-1:0] places_reg, places_next;
    logic                ms_reg, ms_next;
    logic                sgn_reg, sgn_next;

    // Per-value working registers.
    logic [INT_W-1:0]  ip_reg, ip_next;
    logic [FRAC_W-1:0] fp_reg, fp_next;
    logic              neg_reg, neg_next;
    logic              ms_item_reg, ms_item_next;
    logic              round_reg, round_next;
    logic [REL_W-1:0]  nf_reg, nf_next;
    logic [REL_W-1:0]  end_reg, end_next;
    logic [REL_W-1:0]  k_reg, k_next;
    logic [REL_W-1:0]  lastn9_reg, lastn9_next;
    logic [REL_W-1:0]  q_reg, q_next;
    logic              lead_reg, lead_next;
    logic              pt_done_reg, pt_done_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CHAR_W-1:0] pend_char_reg, pend_char_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    // Fraction digits, most significant at index zero.
    logic [BCD_W-1:0] frac_reg[FRAC_N];
    logic             frac_wr;
    logic             frac_shift;

    // Datapath helpers.
    logic [VAL_W-1:0]   in_val;
    logic               in_neg;
    logic [PLACES_W:0]  places_sum;
    logic [REL_W-1:0]   nf_in;
    logic [PROD_W-1:0]  prod;
    logic [BCD_W-1:0]   frac_digit;
    logic               carry_int;
    logic [IP_BITS-1:0] bcd_bin;
    bcd_ctrl_t          bcd_ctrl;
    bcd_stat_t          bcd_stat;
    logic               is_frac;
    logic [BCD_W-1:0]   raw_digit;
    logic [BCD_W-1:0]   digit;
    logic [REL_W-1:0]   point_rel;
    logic [REL_W-1:0]   point_last;
    logic               out_free;
    logic               step_ok;
    logic               emit;
    logic [CHAR_W-1:0]  emit_char;

    // Sign handling: in signed mode a negative value is negated to its magnitude.
    always_comb begin
        in_val = {s_int_part, s_frac_part};
        in_neg = s_negative_flag;
        if (sgn_reg) begin
            in_neg = s_int_part[INT_W-1];
            if (in_neg) begin
                in_val = ~in_val + VAL_W'(1);
            end
        end
    end

    // Number of fraction digits, capped by the buffer.
    assign places_sum = {1'b0, places_reg} + (ms_reg ? (PLACES_W+1)'(MS_SHIFT) : '0);
    assign nf_in      = (int'(places_sum) > FRAC_CAP) ? REL_W'(FRAC_CAP) : REL_W'(places_sum);

    // One fraction digit per cycle: multiply by ten as 8x + 2x.
    assign prod       = {1'b0, fp_reg, 3'b000} + {3'b000, fp_reg, 1'b0};
    assign frac_digit = prod[PROD_W-1:FRAC_W];

    // A rounding carry reaches the integer part when no fraction digit can absorb it.
    assign carry_int = fp_reg[FRAC_W-1] && (lastn9_reg == REL_W'(IP_DIGITS - 1));
    assign bcd_bin   = {1'b0, ip_reg} + IP_BITS'(carry_int);

    // Digit at the current position, with the rounding applied to the fraction.
    assign is_frac   = (q_reg >= REL_W'(IP_DIGITS));
    assign raw_digit = is_frac ? frac_reg[0] : bcd_stat.head;
    always_comb begin
        digit = raw_digit;
        if (is_frac && round_reg) begin
            if (q_reg > lastn9_reg) begin
                digit = '0;
            end else if (q_reg == lastn9_reg) begin
                digit = raw_digit + 1'b1;
            end
        end
    end

    assign point_rel  = ms_item_reg ? REL_W'(IP_DIGITS + MS_SHIFT) : REL_W'(IP_DIGITS);
    assign point_last = point_rel - 1'b1;
    assign out_free   = !m_valid_reg || m_ready;
    assign step_ok    = !pend_valid_reg || out_free;

    fpdec_bcd #(
        .NUM_DIGITS (IP_DIGITS),
        .BIN_W      (IP_BITS)
    ) u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bcd_ctrl),
        .bin_in  (bcd_bin),
        .stat    (bcd_stat)
    );

    // Next-state logic for the sequencer, the character queue and the output register.
    always_comb begin
        state_next      = state_reg;
        places_next     = places_reg;
        ms_next         = ms_reg;
        sgn_next        = sgn_reg;
        ip_next         = ip_reg;
        fp_next         = fp_reg;
        neg_next        = neg_reg;
        ms_item_next    = ms_item_reg;
        round_next      = round_reg;
        nf_next         = nf_reg;
        end_next        = end_reg;
        k_next          = k_reg;
        lastn9_next     = lastn9_reg;
        q_next          = q_reg;
        lead_next       = lead_reg;
        pt_done_next    = pt_done_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        frac_wr         = 1'b0;
        frac_shift      = 1'b0;
        bcd_ctrl        = '0;
        emit            = 1'b0;
        emit_char       = CH_POINT;

        // Configuration writes.
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_DECIMAL_PLACES:   places_next = cfg_data[PLACES_W-1:0];
                REG_MILLISECOND_MODE: ms_next     = cfg_data[0];
                REG_SIGNED_INPUT:     sgn_next    = cfg_data[0];
                default: ;
            endcase
        end

        // A taken transaction frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ip_next      = in_val[VAL_W-1:FRAC_W];
                    fp_next      = in_val[FRAC_W-1:0];
                    neg_next     = in_neg;
                    ms_item_next = ms_reg;
                    nf_next      = nf_in;
                    end_next     = REL_W'(IP_DIGITS - SHORT) + nf_in;
                    k_next       = '0;
                    lastn9_next  = REL_W'(IP_DIGITS - 1);
                    state_next   = (nf_in == '0) ? ST_LOAD : ST_FRAC;
                end
            end
            ST_FRAC: begin
                frac_wr = 1'b1;
                fp_next = prod[FRAC_W-1:0];
                if (frac_digit != DIGIT_NINE) begin
                    lastn9_next = REL_W'(IP_DIGITS) + k_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == nf_reg - 1'b1) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                round_next      = fp_reg[FRAC_W-1];
                bcd_ctrl.load   = 1'b1;
                pend_valid_next = neg_reg;
                pend_char_next  = CH_MINUS;
                q_next          = '0;
                lead_next       = 1'b1;
                pt_done_next    = 1'b0;
                state_next      = ST_CONV;
            end
            ST_CONV: begin
                if (bcd_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (step_ok) begin
                    if (q_reg == point_rel && !pt_done_reg) begin
                        emit         = 1'b1;
                        emit_char    = CH_POINT;
                        pt_done_next = 1'b1;
                    end else begin
                        // Leading zeros are dropped, but one digit stays before the point.
                        if (!(lead_reg && digit == '0 && q_reg < point_last)) begin
                            emit      = 1'b1;
                            emit_char = CH_ZERO + CHAR_W'(digit);
                            lead_next = 1'b0;
                        end
                        if (is_frac) begin
                            frac_shift = 1'b1;
                        end else begin
                            bcd_ctrl.shift = 1'b1;
                        end
                        q_next = q_reg + 1'b1;
                        if (q_reg == end_reg - 1'b1) begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_char_next     = pend_char_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The held character goes out once the next one is known, so the last flag is exact.
        if (emit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_char_next  = pend_char_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_char_next  = emit_char;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            places_reg     <= PLACES_RESET;
            ms_reg         <= 1'b0;
            sgn_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            places_reg     <= places_next;
            ms_reg         <= ms_next;
            sgn_reg        <= sgn_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        ip_reg        <= ip_next;
        fp_reg        <= fp_next;
        neg_reg       <= neg_next;
        ms_item_reg   <= ms_item_next;
        round_reg     <= round_next;
        nf_reg        <= nf_next;
        end_reg       <= end_next;
        k_reg         <= k_next;
        lastn9_reg    <= lastn9_next;
        q_reg         <= q_next;
        lead_reg      <= lead_next;
        pt_done_reg   <= pt_done_next;
        pend_char_reg <= pend_char_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
    end

    // Fraction digit store: written in order, read out by shifting toward index zero.
    always_ff @(posedge aclk) begin
        if (frac_wr) begin
            frac_reg[k_reg[FIDX_W-1:0]] <= frac_digit;
        end else if (frac_shift) begin
            for (int j = 0; j < FRAC_N - 1; j++) begin
                frac_reg[j] <= frac_reg[j+1];
            end
            frac_reg[FRAC_N-1] <= '0;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

[rtl/core/fpdec_checker.sv]
module fpdec_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic [fpdec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [fpdec_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [fpdec_pkg::INT_W-1:0]      s_int_part,
    input logic [fpdec_pkg::FRAC_W-1:0]     s_frac_part,
    input logic                             s_negative_flag,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [fpdec_pkg::CHAR_W-1:0]     m_char_code,
    input logic                             m_last_char
);
    import fpdec_pkg::*;

    // A stalled result transaction keeps its character and flag.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_code) && $stable(m_last_char))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // One value at a time: taking an input closes the input side.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a value is in progress");

    // Only digits, the minus sign and the point are ever produced.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_char_code >= CH_ZERO && m_char_code <= CH_NINE) ||
                    m_char_code == CH_MINUS || m_char_code == CH_POINT)
        else $error("unexpected character code");

    // A point is always followed by at least one digit.
    a_point_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_code == CH_POINT |-> !m_last_char)
        else $error("text ends in a point");

endmodule

bind fixed_point_to_decimal_text fpdec_checker u_fpdec_checker (.*);

[tb/fixed_point_to_decimal_text_test.sv]
`timescale 1ns / 1ps

module fixed_point_to_decimal_text_test;
    import fpdec_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_GAP   = 8;
    localparam int END_GAP      = 120;

    // One character of the expected text.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [INT_W-1:0]      s_int_part;
    logic [FRAC_W-1:0]     s_frac_part;
    logic                  s_negative_flag;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAR_W-1:0]     m_char_code;
    logic                  m_last_char;

    // Characters still owed by the block, oldest first.
    text_char_t expected_chars[$];

    // Local copy of the configuration registers.
    logic [PLACES_W-1:0] places_reg;
    logic                ms_reg;
    logic                signed_reg;

    int error_count        = 0;
    int values_sent        = 0;
    int chars_checked      = 0;
    int settings_used      = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_request       = 0;

    fixed_point_to_decimal_text i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_int_part      (s_int_part),
        .s_frac_part     (s_frac_part),
        .s_negative_flag (s_negative_flag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_code     (m_char_code),
        .m_last_char     (m_last_char)
    );

    // Clock with a 4 ns period.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Work out the text for one value under the current settings and queue it.
    function automatic void predict_text(input logic [INT_W-1:0] int_in,
                                         input logic [FRAC_W-1:0] frac_in,
                                         input logic neg_in);
        logic [BCD_W-1:0]  digits [BUFFER_DIGITS_DEF+3];
        logic [63:0]       whole;
        logic [INT_W-1:0]  ip;
        logic [FRAC_W-1:0] fp;
        logic [FRAC_W+3:0] prod;
        logic              neg;
        logic              carry;
        int                first;
        int                stop;
        int                point;
        int                left;
        int                pos;
        text_char_t        ch;
        text_char_t        text[$];

        ip = int_in;
        fp = frac_in;

        // The sign comes either from the flag or from the top bit of the 64-bit value.
        if (signed_reg) begin
            neg = ip[INT_W-1];
            if (neg) begin
                whole    = -{ip, fp};
                {ip, fp} = whole;
            end
        end else begin
            neg = neg_in;
        end

        foreach (digits[i]) digits[i] = '0;

        // Integer digits fill leftwards from the point.
        first = INT_DIGITS_DEF;
        stop  = INT_DIGITS_DEF;
        point = INT_DIGITS_DEF;
        for (left = INT_DIGITS_DEF; left > 0 && ip != 0; left--) begin
            first--;
            digits[first] = BCD_W'(ip % 10);
            ip = ip / 10;
        end

        // Count of fraction places, widened by millisecond mode and then capped.
        left = int'(places_reg);
        if (ms_reg) begin
            left  += MS_SHIFT;
            point += MS_SHIFT;
        end
        if (left > BUFFER_DIGITS_DEF - INT_DIGITS_DEF)
            left = BUFFER_DIGITS_DEF - INT_DIGITS_DEF;

        while (left > 0 && fp != 0) begin
            prod = {4'd0, fp} * 36'd10;
            digits[stop] = prod[FRAC_W+3:FRAC_W];
            fp = prod[FRAC_W-1:0];
            stop++;
            left--;
        end

        // An exact fraction pads with zeros; otherwise round on the next bit.
        if (left > 0) begin
            stop += left;
        end else begin
            pos   = stop;
            carry = fp[FRAC_W-1];
            while (carry && pos > 0) begin
                pos--;
                if (digits[pos] == DIGIT_NINE) begin
                    digits[pos] = '0;
                end else begin
                    digits[pos] = digits[pos] + 1'b1;
                    carry = 1'b0;
                end
            end
            if (pos < first)
                first = pos;
        end

        // Strip leading zeros but keep one digit before the point.
        while (first < point && digits[first] == '0)
            first++;
        if (first >= point)
            first = point - 1;
        if (stop > BUFFER_DIGITS_DEF)
            stop = BUFFER_DIGITS_DEF;

        if (neg) begin
            ch.code = CH_MINUS;
            ch.last = 1'b0;
            text.push_back(ch);
        end
        for (int i = first; i < stop; i++) begin
            if (i == point) begin
                ch.code = CH_POINT;
                ch.last = 1'b0;
                text.push_back(ch);
            end
            ch.code = CH_ZERO + CHAR_W'(digits[i]);
            ch.last = 1'b0;
            text.push_back(ch);
        end
        if (text.size() > 0)
            text[text.size()-1].last = 1'b1;
        foreach (text[i]) expected_chars.push_back(text[i]);
    endfunction

    // Mix of word shapes: small, near the top, around the half point, few bits set, any.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0:       return 32'($urandom_range(99));
            1:       return 32'hFFFF_FFFF - 32'($urandom_range(15));
            2:       return 32'h8000_0000 ^ 32'($urandom_range(15));
            3:       return 32'($urandom_range(255)) << 24;
            default: return $urandom();
        endcase
    endfunction

    // Offer one value and wait for its transaction; valid stays high afterwards.
    task automatic send_value(input logic [INT_W-1:0] int_in,
                              input logic [FRAC_W-1:0] frac_in,
                              input logic neg_in);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_int_part      <= int_in;
        s_frac_part     <= frac_in;
        s_negative_flag <= neg_in;
        predict_text(int_in, frac_in, neg_in);
        values_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every queued character has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_GAP) @(posedge aclk);
    endtask

    // Write all three registers on consecutive cycles; only called while idle.
    task automatic apply_config(input logic [PLACES_W-1:0] places,
                                input logic ms,
                                input logic sgn);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DECIMAL_PLACES;
        cfg_data  <= CFG_DATA_W'(places);
        @(posedge aclk);
        cfg_index <= REG_MILLISECOND_MODE;
        cfg_data  <= CFG_DATA_W'(ms);
        @(posedge aclk);
        cfg_index <= REG_SIGNED_INPUT;
        cfg_data  <= CFG_DATA_W'(sgn);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        places_reg = places;
        ms_reg     = ms;
        signed_reg = sgn;
        settings_used++;
    endtask

    // Values under the register defaults: six places, seconds, unsigned.
    task automatic test_reset_defaults();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_value(32'd0, 32'd0, 1'b0);
        send_value(32'd1, 32'h8000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_value(32'd12345, 32'h1999_999A, 1'b0);
        wait_drained();
    endtask

    // Rounding carries, no places, the place cap, millisecond mode and signed input.
    task automatic test_special_cases();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        // No places: no point, and the rounding carry reaches the integer digits.
        apply_config(4'd0, 1'b0, 1'b0);
        send_value(32'd0, 32'h7FFF_FFFF, 1'b0);
        send_value(32'd0, 32'h8000_0000, 1'b0);
        send_value(32'd9, 32'hC000_0000, 1'b0);
        send_value(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_value(32'd5, 32'd0, 1'b1);
        wait_drained();

        // Largest register value is capped at fourteen places.
        apply_config(4'd15, 1'b0, 1'b0);
        send_value(32'd0, 32'd1, 1'b0);
        send_value(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // Millisecond mode, with and without the cap.
        apply_config(4'd14, 1'b1, 1'b0);
        send_value(32'd1, 32'h0020_C49C, 1'b0);
        send_value(32'd0, 32'hFFFF_FFFF, 1'b0);
        wait_drained();
        apply_config(4'd0, 1'b1, 1'b0);
        send_value(32'd2, 32'h4000_0000, 1'b0);
        send_value(32'd0, 32'd0, 1'b1);
        wait_drained();

        // Signed input, including the most negative value and the ignored flag.
        apply_config(4'd3, 1'b0, 1'b1);
        send_value(32'h8000_0000, 32'd0, 1'b0);
        send_value(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_value(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_value(32'd0, 32'd0, 1'b1);
        send_value(32'hFFFF_FFFE, 32'h8000_0000, 1'b1);
        wait_drained();
    endtask

    // Random values in batches, each batch under its own settings.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        logic [PLACES_W-1:0] places;

        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int batch = 0; batch < 4; batch++) begin
            if (batch == 0)
                places = '0;
            else if (batch == 1)
                places = '1;
            else
                places = PLACES_W'($urandom_range(15));
            wait_drained();
            apply_config(places, 1'($urandom_range(1)), 1'($urandom_range(1)));
            for (int k = 0; k < count / 4; k++)
                send_value(pick_word(), pick_word(), 1'($urandom_range(1)));
        end
        wait_drained();
    endtask

    // Long output stall while values keep coming, so the input side backs up.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        apply_config(4'd14, 1'b1, 1'b1);
        hold_request = 800;
        for (int k = 0; k < 12; k++)
            send_value(pick_word(), pick_word(), 1'($urandom_range(1)));
        wait_drained();
    endtask

    // Result side ready, with random stalls and the occasional long hold-off.
    initial begin
        int hold_left;

        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Compare each character transaction with the oldest expectation.
    always @(posedge aclk) begin
        text_char_t want;

        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                error_count++;
                $error("char_code: nothing expected, got 0x%02h (last_char %0b)",
                       m_char_code, m_last_char);
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_char_code !== want.code) begin
                    error_count++;
                    $error("char_code: expected 0x%02h, got 0x%02h", want.code, m_char_code);
                end
                if (m_last_char !== want.last) begin
                    error_count++;
                    $error("last_char: expected %0b, got %0b", want.last, m_last_char);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fixed_point_to_decimal_text_test: errors");
            $finish;
        end
    end

    initial begin
        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= REG_DECIMAL_PLACES;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_int_part      <= '0;
        s_frac_part     <= '0;
        s_negative_flag <= 1'b0;
        places_reg = PLACES_RESET;
        ms_reg     = 1'b0;
        signed_reg = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_special_cases();
        test_random_traffic(0, 0, 100);
        test_random_traffic(64, 0, 100);
        test_random_traffic(0, 64, 100);
        test_random_traffic(15, 15, 100);
        test_backpressure();

        wait_drained();
        repeat (END_GAP) @(posedge aclk);

        $display("Converted %0d values into %0d checked characters under %0d register settings,",
                 values_sent, chars_checked, settings_used);
        $display("with random idling on both sides and one long output stall.");
        if (error_count == 0)
            $display("fixed_point_to_decimal_text_test: clean");
        else
            $display("fixed_point_to_decimal_text_test: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/core/fpdec_pkg.sv
rtl/core/fpdec_bcd.sv
rtl/core/fixed_point_to_decimal_text.sv
rtl/core/fpdec_checker.sv
tb/fixed_point_to_decimal_text_test.sv
